// ===== rtl/core/iirdf2_pkg.sv =====
// ============================================================================
// iirdf2_pkg
// Shared types, constants and helpers of the direct form II biquad filter.
// ============================================================================
package iirdf2_pkg;

    // Default build of the filter
    localparam int DEFAULT_FILTER_ORDER = 2;
    localparam int DEFAULT_SAMPLE_BITS  = 16;

    // Fixed arithmetic widths
    localparam int MAX_ORDER = 3;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int STATE_W   = 32;
    localparam int PROD_W    = COEF_W + STATE_W;
    localparam int ACC_W     = 52;
    localparam int Q_W       = ACC_W - COEF_FRAC;
    localparam int CFG_IDX_W = 3;
    localparam int TAP_W     = $clog2(MAX_ORDER + 1);

    // Half an LSB of the Q2.14 result, added before the floor shift
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC - 1);

    // Coefficient power-on values
    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF_ZERO = 3'd0,
        REG_FF_ONE  = 3'd1,
        REG_FF_TWO  = 3'd2,
        REG_FB_ONE  = 3'd3,
        REG_FB_TWO  = 3'd4
    } cfg_reg_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t ff0;
        coef_t ff1;
        coef_t ff2;
        coef_t fb1;
        coef_t fb2;
    } coef_set_t;

    // Command word from the controller to the datapath
    typedef struct packed {
        logic             load;     // take the new item into the accumulators
        logic             mul;      // issue one product
        logic             mul_fb;   // product goes into the feedback sum
        logic             mul_w;    // product is b0 times the new intermediate
        logic [TAP_W-1:0] tap;      // delay tap k, 1 is the newest
        logic             round_w;  // round and saturate the intermediate
        logic             finish;   // round the output, load it, advance taps
    } dp_cmd_t;

    // Coefficient of tap k; third-order taps have no register and read zero
    function automatic coef_t coef_pick(coef_set_t c, logic fb, logic [TAP_W-1:0] tap);
        coef_t r;
        case (tap)
            TAP_W'(1): r = fb ? c.fb1 : c.ff1;
            TAP_W'(2): r = fb ? c.fb2 : c.ff2;
            default:   r = COEF_ZERO;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/iirdf2_regs.sv =====
// ============================================================================
// iirdf2_regs
// Coefficient register bank written through the configuration channel.
// ============================================================================
module iirdf2_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iirdf2_pkg::COEF_W-1:0]      cfg_data,
    output iirdf2_pkg::coef_set_t              coef
);

    iirdf2_pkg::coef_set_t coef_reg;
    iirdf2_pkg::coef_set_t coef_next;

    // Always ready; writes outside the map drop
    assign cfg_ready = 1'b1;

    // Decode the register index
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (iirdf2_pkg::cfg_reg_t'(cfg_index))
                iirdf2_pkg::REG_FF_ZERO: coef_next.ff0 = cfg_data;
                iirdf2_pkg::REG_FF_ONE:  coef_next.ff1 = cfg_data;
                iirdf2_pkg::REG_FF_TWO:  coef_next.ff2 = cfg_data;
                iirdf2_pkg::REG_FB_ONE:  coef_next.fb1 = cfg_data;
                iirdf2_pkg::REG_FB_TWO:  coef_next.fb2 = cfg_data;
                default:                 coef_next = coef_reg;
            endcase
        end
    end

    // Hold coefficients; b0 powers up as 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.ff0 <= iirdf2_pkg::COEF_ONE;
            coef_reg.ff1 <= iirdf2_pkg::COEF_ZERO;
            coef_reg.ff2 <= iirdf2_pkg::COEF_ZERO;
            coef_reg.fb1 <= iirdf2_pkg::COEF_ZERO;
            coef_reg.fb2 <= iirdf2_pkg::COEF_ZERO;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ===== rtl/core/iirdf2_ctrl.sv =====
// ============================================================================
// iirdf2_ctrl
// Sequencer for one item: products over the taps, rounding, output hand-off.
// ============================================================================
module iirdf2_ctrl
#(
    parameter int FILTER_ORDER = iirdf2_pkg::DEFAULT_FILTER_ORDER
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output iirdf2_pkg::dp_cmd_t   cmd
);

    localparam int STEP_W = $clog2(2 * FILTER_ORDER);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * FILTER_ORDER - 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MAC     = 6'b000010,
        S_ROUND_W = 6'b000100,
        S_MUL_B0  = 6'b001000,
        S_ACC     = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                // Even steps feed back a_k, odd steps feed forward b_k, oldest tap first
                cmd.mul    = 1'b1;
                cmd.mul_fb = !step_reg[0];
                cmd.tap    = iirdf2_pkg::TAP_W'(FILTER_ORDER)
                           - iirdf2_pkg::TAP_W'(step_reg >> 1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_ROUND_W;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_ROUND_W:
            begin
                cmd.round_w = 1'b1;
                state_next  = S_MUL_B0;
            end
            S_MUL_B0:
            begin
                cmd.mul    = 1'b1;
                cmd.mul_w  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Wait for the output register to drain
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on finish, clear on take
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/iirdf2_dp.sv =====
// ============================================================================
// iirdf2_dp
// Shared 16x32 multiplier, feedback and output accumulators, delay line.
// ============================================================================
module iirdf2_dp
#(
    parameter int FILTER_ORDER = iirdf2_pkg::DEFAULT_FILTER_ORDER,
    parameter int SAMPLE_BITS  = iirdf2_pkg::DEFAULT_SAMPLE_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  iirdf2_pkg::dp_cmd_t         cmd,
    input  iirdf2_pkg::coef_set_t       coef,
    input  logic [SAMPLE_BITS-1:0]      x_in,
    output logic [SAMPLE_BITS-1:0]      y_out,
    output logic                        clip_out
);

    localparam int ACC_W   = iirdf2_pkg::ACC_W;
    localparam int STATE_W = iirdf2_pkg::STATE_W;
    localparam int PROD_W  = iirdf2_pkg::PROD_W;
    localparam int Q_W     = iirdf2_pkg::Q_W;
    localparam int FRAC    = iirdf2_pkg::COEF_FRAC;

    localparam logic signed [STATE_W-1:0] W_MAX = {1'b0, {(STATE_W - 1){1'b1}}};
    localparam logic signed [STATE_W-1:0] W_MIN = {1'b1, {(STATE_W - 1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0]    Y_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]    Y_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [STATE_W-1:0]  delay_reg [FILTER_ORDER];
    logic                       sub_w_reg;
    logic                       add_y_reg;

    logic signed [ACC_W-1:0]    acc_w_reg;
    logic signed [ACC_W-1:0]    acc_w_next;
    logic signed [ACC_W-1:0]    acc_y_reg;
    logic signed [ACC_W-1:0]    acc_y_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [STATE_W-1:0]  w_reg;
    logic signed [STATE_W-1:0]  w_next;
    logic [SAMPLE_BITS-1:0]     y_reg;
    logic [SAMPLE_BITS-1:0]     y_next;
    logic                       clip_reg;
    logic                       clip_next;

    iirdf2_pkg::coef_t          coef_sel;
    logic signed [STATE_W-1:0]  data_tap;
    logic signed [STATE_W-1:0]  data_sel;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [Q_W-1:0]      w_q;
    logic signed [ACC_W-1:0]    y_sum;
    logic signed [Q_W-1:0]      y_q;

    // Select the tap value for the current product
    always_comb
    begin
        data_tap = '0;
        for (int j = 0; j < FILTER_ORDER; j++)
        begin
            if (cmd.tap == iirdf2_pkg::TAP_W'(j + 1))
            begin
                data_tap = delay_reg[j];
            end
        end
    end

    // Multiplier operands
    assign coef_sel  = cmd.mul_w ? coef.ff0 : iirdf2_pkg::coef_pick(coef, cmd.mul_fb, cmd.tap);
    assign data_sel  = cmd.mul_w ? w_reg : data_tap;
    assign prod_next = cmd.mul ? coef_sel * data_sel : prod_reg;

    // Accumulate the registered product, or load a new item
    always_comb
    begin
        acc_w_next = acc_w_reg;
        acc_y_next = acc_y_reg;
        if (cmd.load)
        begin
            acc_w_next = ACC_W'($signed(x_in)) <<< FRAC;
            acc_y_next = '0;
        end
        else
        begin
            if (sub_w_reg)
            begin
                acc_w_next = acc_w_reg - ACC_W'(prod_reg);
            end
            if (add_y_reg)
            begin
                acc_y_next = acc_y_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Round half up and saturate the intermediate to 32 bits
    always_comb
    begin
        w_sum  = acc_w_reg + iirdf2_pkg::HALF_LSB;
        w_q    = w_sum[ACC_W-1:FRAC];
        w_next = w_reg;
        if (cmd.round_w)
        begin
            if ((w_q[Q_W-1:STATE_W-1] == '0) || (w_q[Q_W-1:STATE_W-1] == '1))
            begin
                w_next = w_q[STATE_W-1:0];
            end
            else
            begin
                w_next = w_q[Q_W-1] ? W_MIN : W_MAX;
            end
        end
    end

    // Round half up and saturate the output to the sample width
    always_comb
    begin
        y_sum     = acc_y_reg + iirdf2_pkg::HALF_LSB;
        y_q       = y_sum[ACC_W-1:FRAC];
        y_next    = y_reg;
        clip_next = clip_reg;
        if (cmd.finish)
        begin
            if ((y_q[Q_W-1:SAMPLE_BITS-1] == '0) || (y_q[Q_W-1:SAMPLE_BITS-1] == '1))
            begin
                y_next    = y_q[SAMPLE_BITS-1:0];
                clip_next = 1'b0;
            end
            else
            begin
                y_next    = y_q[Q_W-1] ? Y_MIN : Y_MAX;
                clip_next = 1'b1;
            end
        end
    end

    // Delay line and product tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < FILTER_ORDER; j++)
            begin
                delay_reg[j] <= '0;
            end
            sub_w_reg <= 1'b0;
            add_y_reg <= 1'b0;
        end
        else
        begin
            sub_w_reg <= cmd.mul && cmd.mul_fb;
            add_y_reg <= cmd.mul && !cmd.mul_fb;
            // Advance the taps with the new intermediate
            if (cmd.finish)
            begin
                delay_reg[0] <= w_reg;
                for (int j = 1; j < FILTER_ORDER; j++)
                begin
                    delay_reg[j] <= delay_reg[j-1];
                end
            end
        end
    end

    // Arithmetic payload registers
    always_ff @(posedge clk)
    begin
        acc_w_reg <= acc_w_next;
        acc_y_reg <= acc_y_next;
        prod_reg  <= prod_next;
        w_reg     <= w_next;
        y_reg     <= y_next;
        clip_reg  <= clip_next;
    end

    assign y_out    = y_reg;
    assign clip_out = clip_reg;

endmodule

// ===== rtl/core/iir_direct_form_two_top.sv =====
// ============================================================================
// iir_direct_form_two_top
// Direct form II IIR filter on a stream of signed samples, Q2.14 coefficients.
// ============================================================================
//
//  Channel   Direction  Signals                     Content
//  s_axis    in         tvalid tready tdata         sample_in
//  m_axis    out        tvalid tready tdata tuser   sample_out, clipped
//  cfg       in         valid ready index data      coefficient write
//
//  The single shared 16x32 multiplier forms 2*FILTER_ORDER + 1 products in
//  turn for each item, and no new item is accepted until the current one has
//  been loaded into the output register.
//  Reset clears the delay line and loads b0 = 1.0, other coefficients zero.
//  The result sits in an output register; the next item is accepted while it
//  waits, and that item's result holds in the accumulator until it is taken.
//
module iir_direct_form_two_top
#(
    parameter int FILTER_ORDER = iirdf2_pkg::DEFAULT_FILTER_ORDER,
    parameter int SAMPLE_BITS  = iirdf2_pkg::DEFAULT_SAMPLE_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input samples
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample_in
    // Filtered samples
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // sample_out
    output logic                                  m_axis_tuser,  // clipped
    // Coefficient writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf2_pkg::COEF_W-1:0]         cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    iirdf2_pkg::coef_set_t      coef;
    iirdf2_pkg::dp_cmd_t        cmd;
    logic [SAMPLE_BITS-1:0]     y_out;

    iirdf2_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    iirdf2_ctrl
    #(
        .FILTER_ORDER (FILTER_ORDER)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    iirdf2_dp
    #(
        .FILTER_ORDER (FILTER_ORDER),
        .SAMPLE_BITS  (SAMPLE_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .coef     (coef),
        .x_in     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .y_out    (y_out),
        .clip_out (m_axis_tuser)
    );

    // Pad the sample to whole bytes
    assign m_axis_tdata = OUT_W'(y_out);

endmodule

// ===== rtl/core/iirdf2_checker.sv =====
// ============================================================================
// iirdf2_checker
// Port-level checks of the filter, bound to the top level.
// ============================================================================
module iirdf2_checker
#(
    parameter int SAMPLE_BITS = iirdf2_pkg::DEFAULT_SAMPLE_BITS
)
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    input logic                                   m_axis_tuser
);

    localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

    // One item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accept");

    // No result appears the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

    // A clipped result sits on a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[SAMPLE_BITS-1:0] == Y_MAX) ||
            (m_axis_tdata[SAMPLE_BITS-1:0] == Y_MIN))
    else $error("clipped flag without a saturated sample");

endmodule

bind iir_direct_form_two_top iirdf2_checker
#(
    .SAMPLE_BITS (SAMPLE_BITS)
)
u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/iir_biquad_sb_pkg.sv =====
`timescale 1ns / 100ps
// ============================================================================
// iir_biquad_sb_pkg
// Scoreboard for the direct form II biquad: keeps its own coefficients and
// delay line, predicts every filtered sample in 64-bit fixed point, and
// compares each delivered sample with the oldest prediction.
// ============================================================================
package iir_biquad_sb_pkg;

    import iirdf2_pkg::*;

    localparam int     MAX_REPORTS = 20;
    localparam longint W_MAX       = 64'sd2147483647;
    localparam longint W_MIN       = -64'sd2147483648;
    localparam longint Y_MAX       = 64'sd32767;
    localparam longint Y_MIN       = -64'sd32768;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
    } filt_result_t;

    class biquad_scoreboard;
        coef_t        b0, b1, b2, a1, a2;
        int           w_hist [2];       // newest intermediate first
        filt_result_t pending_q [$];
        int           mismatches;
        int           samples_in;
        int           results_out;
        int           clip_count;
        int           w_sat_count;

        function new();
            b0          = COEF_ONE;
            b1          = COEF_ZERO;
            b2          = COEF_ZERO;
            a1          = COEF_ZERO;
            a2          = COEF_ZERO;
            w_hist[0]   = 0;
            w_hist[1]   = 0;
            mismatches  = 0;
            samples_in  = 0;
            results_out = 0;
            clip_count  = 0;
            w_sat_count = 0;
        endfunction

        // Mirror a coefficient write; indexes past the register map are dropped
        function void write_coef(logic [CFG_IDX_W-1:0] idx, coef_t value);
            case (idx)
                REG_FF_ZERO: b0 = value;
                REG_FF_ONE:  b1 = value;
                REG_FF_TWO:  b2 = value;
                REG_FB_ONE:  a1 = value;
                REG_FB_TWO:  a2 = value;
                default: ;
            endcase
        endfunction

        // Floor of (v + half LSB) / 2^14
        function longint round_half_up(longint v);
            return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        // Run one sample through the filter and queue the expected output
        function void note_sample(logic signed [15:0] x);
            longint       acc_w;
            longint       acc_y;
            longint       w_full;
            longint       y_full;
            int           w;
            filt_result_t r;

            acc_w = longint'(x) <<< COEF_FRAC;
            acc_w = acc_w - longint'(a1) * longint'(w_hist[0]);
            acc_w = acc_w - longint'(a2) * longint'(w_hist[1]);
            acc_y = longint'(b1) * longint'(w_hist[0]) + longint'(b2) * longint'(w_hist[1]);

            // Intermediate saturates silently to 32 bits
            w_full = round_half_up(acc_w);
            if (w_full > W_MAX)
            begin
                w_full = W_MAX;
                w_sat_count++;
            end
            else if (w_full < W_MIN)
            begin
                w_full = W_MIN;
                w_sat_count++;
            end
            w = int'(w_full);
            acc_y = acc_y + longint'(b0) * longint'(w);

            // Advance the delay line
            w_hist[1] = w_hist[0];
            w_hist[0] = w;

            // Output saturates to the sample range and flags it
            y_full    = round_half_up(acc_y);
            r.clipped = 1'b0;
            if (y_full > Y_MAX)
            begin
                y_full    = Y_MAX;
                r.clipped = 1'b1;
            end
            else if (y_full < Y_MIN)
            begin
                y_full    = Y_MIN;
                r.clipped = 1'b1;
            end
            r.sample = y_full[15:0];
            if (r.clipped)
                clip_count++;
            samples_in++;
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare one delivered item with the oldest expectation
        task check_result(logic [15:0] data, logic clip);
            filt_result_t exp_r;
            results_out++;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("output %0d with no sample outstanding",
                                          $signed(data)));
                return;
            end
            exp_r = pending_q.pop_front();
            if (data !== exp_r.sample)
                report_mismatch($sformatf("output #%0d sample_out %0d, predicted %0d",
                                          results_out, $signed(data), exp_r.sample));
            if (clip !== exp_r.clipped)
                report_mismatch($sformatf("output #%0d clipped %b, predicted %b",
                                          results_out, clip, exp_r.clipped));
        endtask

        // Flag predictions that never came out
        task drain_check();
            if (pending_q.size() != 0)
                report_mismatch($sformatf("%0d predicted outputs never delivered",
                                          pending_q.size()));
        endtask
    endclass

endpackage

// ===== tb/sv/iir_direct_form_two_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// iir_direct_form_two_top_tb
// Drives audio samples and coefficient writes into the biquad filter with
// random gaps on both stream sides and checks every output sample and clip
// flag against a fixed-point prediction of the direct form II recursion.
// ============================================================================
module iir_direct_form_two_top_tb;

    import iirdf2_pkg::*;
    import iir_biquad_sb_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int NUM_SEGMENTS  = 6;
    localparam int SEGMENT_ITEMS = 105;
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_NS   = 10_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;     // sample_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;     // sample_out
    logic                 m_axis_tuser;     // clipped
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    int src_gap_pct;
    int sink_gap_pct;
    int cfg_writes;

    biquad_scoreboard sb = new();

    iir_direct_form_two_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Stall the output side at random
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
    end

    // Predict every accepted sample
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata);
    end

    // Check every delivered item
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Offer one sample, idling first at random; returns on a falling edge
    task automatic send_sample(input logic [15:0] x);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register; valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_coef(idx, value);
        cfg_writes++;
        @(negedge clk);
    endtask

    // Load a full coefficient set
    task automatic load_coefs(input coef_t c0, input coef_t c1, input coef_t c2,
                              input coef_t c3, input coef_t c4);
        write_reg(REG_FF_ZERO, c0);
        write_reg(REG_FF_ONE,  c1);
        write_reg(REG_FF_TWO,  c2);
        write_reg(REG_FB_ONE,  c3);
        write_reg(REG_FB_TWO,  c4);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop input valid and hold until every prediction has been delivered
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int          idle_mode;
        logic [15:0] x;

        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_gap_pct   = 29;
        sink_gap_pct  = 84;
        cfg_writes    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Power-on coefficients pass samples through unchanged
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        wait_idle();

        // Writes past the register map must leave the filter alone
        for (int i = int'(REG_FB_TWO) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 16'h8000);
        cfg_valid <= 1'b0;
        @(negedge clk);
        send_sample(16'h7FFF);
        wait_idle();

        // Drive the output past both limits
        load_coefs(16'sh7FFF, 16'sh8000, 16'sh7FFF, COEF_ZERO, COEF_ZERO);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        wait_idle();

        // Unstable feedback runs the intermediate into 32-bit saturation
        load_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO, 16'sh8000, 16'sh8000);
        repeat (12)
            send_sample(16'h7FFF);
        wait_idle();

        // Random segments, each under its own coefficient set; each idle pattern covers two segments
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            idle_mode = seg / 2;
            case (idle_mode)
                0:
                begin
                    src_gap_pct  = 29;
                    sink_gap_pct = 84;
                end
                1:
                begin
                    src_gap_pct  = 84;
                    sink_gap_pct = 29;
                end
                default:
                begin
                    src_gap_pct  = 0;
                    sink_gap_pct = 0;
                end
            endcase

            case (seg)
                0: load_coefs(16'sd1024, 16'sd2048, 16'sd1024, -16'sd26000, 16'sd10500);
                1: load_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
                2: load_coefs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
                3: load_coefs(coef_t'($urandom_range(65535)), coef_t'($urandom_range(65535)),
                              coef_t'($urandom_range(65535)), coef_t'($urandom_range(65535)),
                              coef_t'($urandom_range(65535)));
                4: load_coefs(coef_t'($urandom_range(65535)), coef_t'($urandom_range(65535)),
                              coef_t'($urandom_range(65535)),
                              coef_t'($urandom_range(16383)) - 16'sd8192,
                              coef_t'($urandom_range(16383)) - 16'sd8192);
                default: load_coefs(coef_t'($urandom_range(65535)), COEF_ZERO, COEF_ZERO,
                                    COEF_ZERO, COEF_ZERO);
            endcase

            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                // Mix limits, small values near zero and full-range noise
                case ($urandom_range(9))
                    0:       x = 16'h7FFF;
                    1:       x = 16'h8000;
                    2:       x = 16'($urandom_range(64)) - 16'd32;
                    default: x = 16'($urandom_range(65535));
                endcase
                send_sample(x);
            end
            wait_idle();
        end

        // Hold a while so that a stray output would still be caught
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.drain_check();

        $display("Covered %0d samples and %0d outputs over %0d coefficient writes",
                 sb.samples_in, sb.results_out, cfg_writes);
        $display("Saw %0d clipped outputs and %0d saturated intermediates, %0d mismatches",
                 sb.clip_count, sb.w_sat_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timeout with %0d outputs outstanding", sb.outstanding());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/iirdf2_pkg.sv
rtl/core/iirdf2_regs.sv
rtl/core/iirdf2_ctrl.sv
rtl/core/iirdf2_dp.sv
rtl/core/iir_direct_form_two_top.sv
rtl/core/iirdf2_checker.sv
tb/sv/iir_biquad_sb_pkg.sv
tb/sv/iir_direct_form_two_top_tb.sv
